// File: hdl/mde_pkg.sv
// shared types and constants for the multiset draw enumerator
// no dependencies
package mde_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_DRAW  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] type_count;
  } in_item_t;

  typedef struct packed {
    logic [47:0] drawn_counts;
    logic [58:0] ways;
    logic [58:0] total_ways;
    logic        exhausted;
    logic        overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_FILL,
    ST_SCAN,
    ST_BINOM,
    ST_BWAIT,
    ST_NEXT,
    ST_OUT,
    ST_EXH
  } state_t;

  typedef enum logic [1:0] {
    BIN_IDLE,
    BIN_MUL,
    BIN_DIV
  } bin_state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_FILL,
    CMD_SCAN,
    CMD_BSTART,
    CMD_BTAKE,
    CMD_NEXT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    out_draw;
    logic    out_exh;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic scan_done;
    logic scan_found;
    logic binom_done;
    logic types_done;
  } status_t;

  localparam int CNT_W = 6;
  localparam int WIDE_W = 64;

endpackage

// File: hdl/mde_binom.sv
// iterative binomial unit, one multiply per factor, then one divide bit per cycle
// result is seed times n choose k; depends on mde_pkg
module mde_binom
  import mde_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  n,
  input  logic [CNT_W-1:0]  k,
  input  logic [WIDE_W-1:0] seed,
  output logic              done,
  output logic [WIDE_W-1:0] result
);

  bin_state_t        st, st_next;
  logic              done_next;
  logic [CNT_W-1:0]  nn;
  logic [CNT_W-1:0]  kk;
  logic [CNT_W-1:0]  i;
  logic [WIDE_W-1:0] c;
  logic [WIDE_W-1:0] num;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] quo;
  logic [5:0]        bit_cnt;
  logic [CNT_W-1:0]  ksym;
  logic [WIDE_W-1:0] rem_sh;
  logic [WIDE_W-1:0] divisor;
  logic              quo_bit;
  logic [WIDE_W-1:0] quo_sh;
  logic              last_factor;

  assign ksym        = (k > n - k) ? n - k : k;
  assign rem_sh      = {rem[WIDE_W-2:0], num[bit_cnt]};
  assign divisor     = WIDE_W'(i) + WIDE_W'(1);
  assign quo_bit     = (rem_sh >= divisor);
  assign quo_sh      = {quo[WIDE_W-2:0], quo_bit};
  assign last_factor = (i + 1'b1 == kk);
  assign result      = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BIN_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next   = st;
    done_next = 1'b0;
    unique case (st)
      BIN_IDLE: begin
        if (start) begin
          if (k > n || ksym == '0) done_next = 1'b1;
          else st_next = BIN_MUL;
        end
      end
      BIN_MUL: st_next = BIN_DIV;
      BIN_DIV: begin
        if (bit_cnt == '0) begin
          if (last_factor) begin
            st_next   = BIN_IDLE;
            done_next = 1'b1;
          end else st_next = BIN_MUL;
        end
      end
      default: st_next = BIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
      unique case (st)
        BIN_IDLE: begin
          if (start) begin
            nn <= n;
            kk <= ksym;
            i  <= '0;
            c  <= (k > n) ? '0 : seed;
          end
        end
        BIN_MUL: begin
          num     <= c * WIDE_W'(nn - i);
          rem     <= '0;
          quo     <= '0;
          bit_cnt <= 6'(WIDE_W - 1);
        end
        BIN_DIV: begin
          rem <= quo_bit ? rem_sh - divisor : rem_sh;
          quo <= quo_sh;
          if (bit_cnt == '0) begin
            c <= quo_sh;
            i <= i + 1'b1;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/mde_datapath.sv
// deck, odometer, binomial product and result registers
// depends on mde_pkg and mde_binom
module mde_datapath
  import mde_pkg::*;
#(
  parameter int MAX_TYPES  = 8,
  parameter int CARD_LIMIT = 62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start_ok,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  input  cmd_t       cmd,
  output status_t    status,
  output phase_t     phase,
  output out_item_t  result,
  output logic       result_valid
);

  localparam int IDX_W = $clog2(MAX_TYPES + 1);
  localparam int AW    = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

  logic [CNT_W-1:0]  deck [MAX_TYPES];
  logic [CNT_W-1:0]  odo  [MAX_TYPES];
  logic [IDX_W-1:0]  type_total;
  logic [CNT_W-1:0]  card_total;
  logic [CNT_W-1:0]  draw_size;
  logic              ovf;
  logic [WIDE_W-1:0] denom;
  logic [WIDE_W-1:0] ways;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  fill_base;
  logic [CNT_W-1:0]  amount;
  logic [CNT_W-1:0]  suffix;
  logic              denom_pass;
  logic              bstart;
  logic [CNT_W-1:0]  bn;
  logic [CNT_W-1:0]  bk;
  logic [WIDE_W-1:0] bseed;
  logic              bdone;
  logic [WIDE_W-1:0] bres;
  logic [CNT_W-1:0]  take;
  logic [CNT_W-1:0]  dcur;
  logic [CNT_W-1:0]  ocur;
  logic [CNT_W:0]    load_sum;
  logic [CNT_W-1:0]  nclamp;
  logic [47:0]       packed_cnt;

  assign dcur     = deck[AW'(ptr - 1'b1)];
  assign ocur     = odo[AW'(ptr - 1'b1)];
  assign take     = (dcur < amount) ? dcur : amount;
  assign load_sum = {1'b0, card_total} + {1'b0, in_item.type_count};
  assign nclamp   = (draw_size < card_total) ? draw_size : card_total;
  assign bstart   = (cmd.op == CMD_BSTART);
  assign bn       = denom_pass ? card_total : deck[AW'(ptr)];
  assign bk       = denom_pass ? nclamp : odo[AW'(ptr)];
  assign bseed    = denom_pass ? WIDE_W'(1) : ways;

  always_comb begin
    packed_cnt = '0;
    for (int j = 0; j < MAX_TYPES; j++) begin
      if (j * 6 < 48 && IDX_W'(j) < type_total) packed_cnt[(j*6)%48 +: 6] = odo[j];
    end
  end

  assign status.fill_done  = (ptr == fill_base);
  assign status.scan_done  = (ptr == '0);
  assign status.scan_found = (ptr != '0) && (suffix != '0) && (ocur < dcur);
  assign status.binom_done = bdone;
  assign status.types_done = !denom_pass && (ptr >= type_total);

  mde_binom u_binom (
    .clk    (clk),
    .rst    (rst),
    .start  (bstart),
    .n      (bn),
    .k      (bk),
    .seed   (bseed),
    .done   (bdone),
    .result (bres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      type_total   <= '0;
      card_total   <= '0;
      draw_size    <= 6'd2;
      ovf          <= 1'b0;
      phase        <= PH_IDLE;
      result_valid <= 1'b0;
      for (int j = 0; j < MAX_TYPES; j++) odo[j] <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        draw_size <= cfg_data;
        phase     <= PH_IDLE;
        for (int j = 0; j < MAX_TYPES; j++) odo[j] <= '0;
      end
      if (start_ok && (in_item.mode == MODE_CLEAR || in_item.mode == MODE_LOAD)) begin
        phase <= PH_IDLE;
        for (int j = 0; j < MAX_TYPES; j++) odo[j] <= '0;
        if (in_item.mode == MODE_CLEAR) begin
          type_total <= '0;
          card_total <= '0;
        end else if (in_item.type_count != '0 && type_total < IDX_W'(MAX_TYPES)) begin
          if (load_sum > (CNT_W+1)'(CARD_LIMIT)) begin
            ovf <= 1'b1;
          end else begin
            deck[AW'(type_total)] <= in_item.type_count;
            type_total <= type_total + 1'b1;
            card_total <= load_sum[CNT_W-1:0];
          end
        end
      end
      unique case (cmd.op)
        CMD_INIT: begin
          ptr        <= type_total;
          fill_base  <= '0;
          amount     <= nclamp;
          suffix     <= '0;
          denom_pass <= (phase == PH_IDLE);
          ways       <= WIDE_W'(1);
          if (phase == PH_IDLE) phase <= PH_RUN;
        end
        CMD_FILL: begin
          odo[AW'(ptr - 1'b1)] <= take;
          amount <= amount - take;
          ptr    <= ptr - 1'b1;
        end
        CMD_SCAN: begin
          if (status.scan_found) begin
            odo[AW'(ptr - 1'b1)] <= ocur + 1'b1;
            amount    <= suffix - 1'b1;
            fill_base <= ptr;
            for (int j = 0; j < MAX_TYPES; j++) begin
              if (IDX_W'(j) >= ptr && IDX_W'(j) < type_total) odo[j] <= '0;
            end
            ptr <= type_total;
          end else if (ptr == '0) begin
            phase <= PH_DONE;
          end else begin
            suffix <= suffix + ocur;
            ptr    <= ptr - 1'b1;
          end
        end
        CMD_NEXT: begin
          ptr    <= '0;
          suffix <= '0;
        end
        CMD_BTAKE: begin
          if (denom_pass) begin
            denom      <= bres;
            denom_pass <= 1'b0;
          end else begin
            ways <= bres;
            ptr  <= ptr + 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.out_draw || cmd.out_exh) begin
        result_valid        <= 1'b1;
        result.drawn_counts <= cmd.out_draw ? packed_cnt : '0;
        result.ways         <= cmd.out_draw ? ways[58:0] : '0;
        result.total_ways   <= cmd.out_draw ? denom[58:0] : '0;
        result.exhausted    <= cmd.out_exh;
        result.overflow     <= ovf;
      end
    end
  end

endmodule

// File: hdl/mde_ctrl.sv
// controller state machine for draw requests
// depends on mde_pkg
module mde_ctrl
  import mde_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start_ok,
  input  logic    is_draw,
  input  phase_t  phase,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t st, st_next;
  logic   from_idle;
  logic   from_idle_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      from_idle <= 1'b0;
    end else begin
      st        <= st_next;
      from_idle <= from_idle_next;
    end
  end

  always_comb begin
    st_next        = st;
    from_idle_next = from_idle;
    cmd            = '{op: CMD_NONE, out_draw: 1'b0, out_exh: 1'b0};
    busy           = (st != ST_IDLE);
    unique case (st)
      ST_IDLE: begin
        if (start_ok && is_draw) begin
          priority if (phase == PH_DONE) st_next = ST_EXH;
          else begin
            st_next        = ST_INIT;
            from_idle_next = (phase == PH_IDLE);
          end
        end
      end
      ST_INIT: begin
        cmd.op  = CMD_INIT;
        st_next = from_idle ? ST_FILL : ST_SCAN;
      end
      ST_FILL: begin
        if (status.fill_done) begin
          cmd.op  = CMD_NEXT;
          st_next = ST_BINOM;
        end else cmd.op = CMD_FILL;
      end
      ST_SCAN: begin
        cmd.op = CMD_SCAN;
        if (status.scan_found) st_next = ST_FILL;
        else if (status.scan_done) st_next = ST_EXH;
      end
      ST_BINOM: begin
        if (status.types_done) st_next = ST_OUT;
        else begin
          cmd.op  = CMD_BSTART;
          st_next = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        if (status.binom_done) begin
          cmd.op  = CMD_BTAKE;
          st_next = ST_BINOM;
        end
      end
      ST_OUT: begin
        cmd.out_draw = 1'b1;
        st_next      = ST_IDLE;
      end
      ST_EXH: begin
        cmd.out_exh = 1'b1;
        st_next     = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/multiset_draw_enumerator.sv
// top level of the multiset draw enumerator
// depends on mde_pkg, mde_ctrl, mde_datapath
//
//  channel   signals                  transfer
//  command   start, busy, cmd         start high and busy low
//  config    cfg_we, cfg_data         cfg_we high
//  result    result_valid, result     one cycle strobe
//
// clear and load keep busy low and give no result
// a draw request steps the odometer, then, unless it is exhausted, runs one
// binomial per type, plus the total on the first draw, one multiply and a
// bit-serial divide per factor; busy high throughout
// rst is synchronous; results cannot be stalled
module multiset_draw_enumerator
  import mde_pkg::*;
#(
  parameter int MAX_TYPES  = 8,
  parameter int CARD_LIMIT = 62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   cmd,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  output logic       result_valid,
  output out_item_t  result
);

  cmd_t    ctl;
  status_t status;
  phase_t  phase;
  logic    start_ok;

  assign start_ok = start && !busy;

  mde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start_ok (start_ok),
    .is_draw  (cmd.mode == MODE_DRAW),
    .phase    (phase),
    .status   (status),
    .cmd      (ctl),
    .busy     (busy)
  );

  mde_datapath #(
    .MAX_TYPES  (MAX_TYPES),
    .CARD_LIMIT (CARD_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .start_ok     (start_ok),
    .in_item      (cmd),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (ctl),
    .status       (status),
    .phase        (phase),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// File: tb/sv/multiset_draw_enumerator_test.sv
// testbench for multiset_draw_enumerator: deck loads, draw enumeration, overflow
// predicts each draw result in a local model and compares it on the result strobe
// depends on mde_pkg and the multiset_draw_enumerator rtl
module multiset_draw_enumerator_test;
  import mde_pkg::*;

  localparam int NTYPES = 8;
  localparam int CARD_MAX = 62;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t cmd = '0;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_data = '0;
  logic result_valid;
  out_item_t result;

  int errors = 0;
  int send_idle_pct = 0;
  out_item_t draw_queue[$];

  logic [5:0] m_size;
  logic [5:0] m_deck[NTYPES];
  int m_types;
  int m_total;
  logic [5:0] m_odo[NTYPES];
  phase_t m_phase;
  logic m_ovf;
  logic [63:0] m_denom;

  always #5 clk = ~clk;

  multiset_draw_enumerator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  function automatic logic [63:0] binom(int n, int k);
    logic [63:0] c;
    c = 1;
    if (k > n) return 0;
    if (k > n - k) k = n - k;
    for (int i = 0; i < k; i++) c = c * (n - i) / (i + 1);
    return c;
  endfunction

  function automatic void spread(int from, int amount);
    int take;
    for (int j = m_types - 1; j >= from; j--) begin
      take = (m_deck[j] < amount) ? m_deck[j] : amount;
      m_odo[j] = 6'(take);
      amount -= take;
    end
  endfunction

  function automatic bit step_odometer();
    int suffix;
    suffix = 0;
    for (int i = m_types - 1; i >= 0; i--) begin
      if (suffix > 0 && m_odo[i] < m_deck[i]) begin
        m_odo[i]++;
        spread(i + 1, suffix - 1);
        return 1;
      end
      suffix += m_odo[i];
    end
    return 0;
  endfunction

  function automatic void restart_enum();
    for (int i = 0; i < NTYPES; i++) m_odo[i] = 0;
    m_phase = PH_IDLE;
    m_denom = 0;
  endfunction

  function automatic void predict_draw(in_item_t it);
    out_item_t r;
    logic [63:0] w;
    int n;
    case (mode_t'(it.mode))
      MODE_CLEAR: begin
        m_types = 0;
        m_total = 0;
        restart_enum();
      end
      MODE_LOAD: begin
        restart_enum();
        if (it.type_count != 0 && m_types < NTYPES) begin
          if (m_total + it.type_count > CARD_MAX) m_ovf = 1;
          else begin
            m_deck[m_types] = it.type_count;
            m_types++;
            m_total += it.type_count;
          end
        end
      end
      MODE_DRAW: begin
        if (m_phase == PH_IDLE) begin
          n = (m_size < m_total) ? m_size : m_total;
          m_denom = binom(m_total, n);
          spread(0, n);
          m_phase = PH_RUN;
        end else if (m_phase == PH_RUN) begin
          if (!step_odometer()) m_phase = PH_DONE;
        end
        r = '0;
        r.overflow = m_ovf;
        if (m_phase != PH_RUN) r.exhausted = 1'b1;
        else begin
          w = 1;
          for (int i = 0; i < m_types; i++) begin
            r.drawn_counts[i*6 +: 6] = m_odo[i];
            w = w * binom(m_deck[i], m_odo[i]);
          end
          r.ways = w[58:0];
          r.total_ways = m_denom[58:0];
        end
        draw_queue = {draw_queue, r};
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result_valid) begin
      if (draw_queue.size() == 0) report_mismatch("unexpected result", 64'd0, 64'd0);
      else begin
        e = draw_queue.pop_front();
        if (result.drawn_counts !== e.drawn_counts)
          report_mismatch("drawn_counts", 64'(result.drawn_counts), 64'(e.drawn_counts));
        if (result.ways !== e.ways) report_mismatch("ways", 64'(result.ways), 64'(e.ways));
        if (result.total_ways !== e.total_ways)
          report_mismatch("total_ways", 64'(result.total_ways), 64'(e.total_ways));
        if (result.exhausted !== e.exhausted)
          report_mismatch("exhausted", 64'(result.exhausted), 64'(e.exhausted));
        if (result.overflow !== e.overflow)
          report_mismatch("overflow", 64'(result.overflow), 64'(e.overflow));
      end
    end
  end

  // one command transfer, with random idle cycles in front
  task automatic send_cmd(logic [1:0] mode, logic [5:0] count);
    in_item_t it;
    it.mode = mode;
    it.type_count = count;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_draw(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (draw_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(logic [5:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_size = v;
    restart_enum();
  endtask

  task automatic test_directed();
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_LOAD, 3);
    send_cmd(MODE_LOAD, 0);
    send_cmd(MODE_LOAD, 2);
    send_cmd(MODE_NONE, 6'h3f);
    repeat (7) send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_LOAD, 60);
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_CLEAR, 6'h2a);
    send_cmd(MODE_LOAD, 62);
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_DRAW, 6'h15);
    send_cmd(MODE_CLEAR, 0);
    repeat (9) send_cmd(MODE_LOAD, 1);
    write_size(62);
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_DRAW, 0);
  endtask

  task automatic test_decks(int n_items);
    int sent, nt;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0)
        write_size($urandom_range(9) == 0 ? 6'd62 : 6'($urandom_range(6)));
      send_cmd(MODE_CLEAR, 6'($urandom));
      sent++;
      nt = $urandom_range(NTYPES + 1);
      for (int i = 0; i < nt; i++) begin
        if ($urandom_range(19) == 0) send_cmd(MODE_LOAD, 6'($urandom));
        else send_cmd(MODE_LOAD, 6'($urandom_range(1, 5)));
        sent++;
      end
      for (int i = $urandom_range(4, 25); i > 0; i--) begin
        if ($urandom_range(15) == 0) send_cmd(2'($urandom), 6'($urandom));
        else send_cmd(MODE_DRAW, 6'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_pause();
    send_cmd(MODE_DRAW, 0);
    drain();
    send_cmd(MODE_DRAW, 0);
  endtask

  initial begin
    m_size = 2;
    m_types = 0;
    m_total = 0;
    m_ovf = 0;
    for (int i = 0; i < NTYPES; i++) m_deck[i] = 0;
    restart_enum();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_size(0);
    send_cmd(MODE_DRAW, 0);
    send_cmd(MODE_DRAW, 0);
    write_size(2);
    send_idle_pct = 19;
    test_decks(570);
    test_pause();
    send_idle_pct = 62;
    test_decks(570);
    send_idle_pct = 0;
    test_decks(570);
    drain();
    if (errors == 0 && draw_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/mde_pkg.sv
hdl/mde_binom.sv
hdl/mde_datapath.sv
hdl/mde_ctrl.sv
hdl/multiset_draw_enumerator.sv
tb/sv/multiset_draw_enumerator_test.sv
